// ----- src/sgjd_pkg.sv -----
// Package for the snake gait joint driver.
// Holds the configuration struct, command codes, stage table and joint geometry.
// No dependencies.
`default_nettype none

package sgjd_pkg;

    localparam int JOINTS_PER_BLOCK = 5;
    localparam int NUM_BLOCKS       = 4;
    localparam int TOTAL_JOINTS     = 20;

    localparam int JOINT_W  = 5;
    localparam int ANGLE_W  = 16;
    localparam int FORCE_W  = 7;
    localparam int TICKS_W  = 8;
    localparam int DRIVE_W  = 8;
    localparam int STAGE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [ANGLE_W-1:0] MAX_ANGLE_RST   = 16'sd1787;
    localparam logic signed [ANGLE_W-1:0] MIN_ANGLE_RST   = -16'sd1787;
    localparam logic [FORCE_W-1:0]        DRIVE_FORCE_RST = 7'd10;
    localparam logic [TICKS_W-1:0]        STAGE_TICKS_RST = 8'd150;

    localparam logic [STAGE_W-1:0] STAGE_LAST_STARTUP = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_FIRST_WAVE   = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_ANGLE   = 2'd0,
        REG_MIN_ANGLE   = 2'd1,
        REG_DRIVE_FORCE = 2'd2,
        REG_STAGE_TICKS = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_LEFT   = 2'd1,
        CMD_RIGHT  = 2'd2,
        CMD_SHRINK = 2'd3
    } t_cmd;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] max_angle;
        logic signed [ANGLE_W-1:0] min_angle;
        logic [FORCE_W-1:0]        drive_force;
        logic [TICKS_W-1:0]        stage_ticks;
    } t_cfg;

    localparam t_cmd STAGE_CMD [0:7][0:NUM_BLOCKS-1] = '{
        '{CMD_LEFT,   CMD_NONE,   CMD_NONE,   CMD_NONE  },
        '{CMD_SHRINK, CMD_LEFT,   CMD_NONE,   CMD_NONE  },
        '{CMD_RIGHT,  CMD_SHRINK, CMD_LEFT,   CMD_NONE  },
        '{CMD_SHRINK, CMD_RIGHT,  CMD_SHRINK, CMD_LEFT  },
        '{CMD_LEFT,   CMD_SHRINK, CMD_RIGHT,  CMD_SHRINK},
        '{CMD_SHRINK, CMD_LEFT,   CMD_SHRINK, CMD_RIGHT },
        '{CMD_RIGHT,  CMD_SHRINK, CMD_LEFT,   CMD_SHRINK},
        '{CMD_SHRINK, CMD_RIGHT,  CMD_SHRINK, CMD_LEFT  }
    };

endpackage

`default_nettype wire

// ----- src/snake_gait_joint_driver.sv -----
// Top level of the snake gait joint driver: input register, drive logic, result register.
// Depends on sgjd_pkg, sgjd_cfg, sgjd_timer and sgjd_drive.
//
//   Channel   Handshake            Payload
//   input     i_valid / o_ready    i_joint_index, i_angle, i_last_joint
//   result    o_valid / i_ready    o_joint_out, o_drive, o_stage_now
//   config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// Each transaction passes the input register and the result register; one is taken per
// cycle while o_ready is high. The stage counter steps as an item marked last joint leaves
// the input register, so each result sees the stage left by the one before it.
// A stall holds the result and a full input; o_ready follows i_ready while both are full.
// Synchronous reset empties both registers and restores stage, tick count and registers.
`default_nettype none

module snake_gait_joint_driver
    import sgjd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [JOINT_W-1:0]        i_joint_index,
    input  wire logic signed [ANGLE_W-1:0] i_angle,
    input  wire logic                      i_last_joint,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [JOINT_W-1:0]             o_joint_out,
    output logic signed [DRIVE_W-1:0]      o_drive,
    output logic [STAGE_W-1:0]             o_stage_now,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg cfg;

    logic                      r_in_valid;
    logic [JOINT_W-1:0]        r_joint;
    logic signed [ANGLE_W-1:0] r_angle;
    logic                      r_last;

    logic                      r_out_valid;
    logic [JOINT_W-1:0]        r_joint_out;
    logic signed [DRIVE_W-1:0] r_drive;
    logic [STAGE_W-1:0]        r_stage_now;

    logic                      out_free;
    logic                      advance;
    logic                      in_take;
    logic [STAGE_W-1:0]        stage;
    logic signed [DRIVE_W-1:0] drive;

    sgjd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sgjd_timer u_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (advance && r_last),
        .i_stage_ticks (cfg.stage_ticks),
        .o_stage       (stage)
    );

    sgjd_drive u_drive (
        .i_joint (r_joint),
        .i_angle (r_angle),
        .i_stage (stage),
        .i_cfg   (cfg),
        .o_drive (drive)
    );

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;
    assign in_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_joint <= i_joint_index;
            r_angle <= i_angle;
            r_last  <= i_last_joint;
        end
        if (advance) begin
            r_joint_out <= r_joint;
            r_drive     <= drive;
            r_stage_now <= stage;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_joint_out = r_joint_out;
    assign o_drive     = r_drive;
    assign o_stage_now = r_stage_now;

endmodule

`default_nettype wire

// ----- src/sgjd_cfg.sv -----
// Configuration register file for the snake gait joint driver.
// Depends on sgjd_pkg.
`default_nettype none

module sgjd_cfg
    import sgjd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_angle   <= MAX_ANGLE_RST;
            r_cfg.min_angle   <= MIN_ANGLE_RST;
            r_cfg.drive_force <= DRIVE_FORCE_RST;
            r_cfg.stage_ticks <= STAGE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_ANGLE:   r_cfg.max_angle   <= i_cfg_data;
                REG_MIN_ANGLE:   r_cfg.min_angle   <= i_cfg_data;
                REG_DRIVE_FORCE: r_cfg.drive_force <= i_cfg_data[FORCE_W-1:0];
                REG_STAGE_TICKS: r_cfg.stage_ticks <= i_cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- src/sgjd_timer.sv -----
// Stage and tick counter that sequences the start-up stages and the wave.
// Depends on sgjd_pkg.
`default_nettype none

module sgjd_timer
    import sgjd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tick,
    input  wire logic [TICKS_W-1:0] i_stage_ticks,
    output logic [STAGE_W-1:0]      o_stage
);

    logic [STAGE_W-1:0] r_stage, n_stage;
    logic [TICKS_W-1:0] r_tick_count, n_tick_count;
    logic [TICKS_W:0]   tick_inc;
    logic               wave;
    logic               stage_done;

    always_comb begin
        tick_inc   = {1'b0, r_tick_count} + {{TICKS_W{1'b0}}, 1'b1};
        wave       = r_stage[STAGE_W-1];
        stage_done = wave ? (r_tick_count >= i_stage_ticks)
                          : (tick_inc >= {1'b0, i_stage_ticks});
        n_stage      = r_stage;
        n_tick_count = r_tick_count;
        if (i_tick) begin
            if (stage_done) begin
                n_tick_count = '0;
                if (wave) begin
                    n_stage = {1'b1, r_stage[1:0] + 2'd1};
                end else begin
                    n_stage = r_stage + 3'd1;
                end
            end else begin
                n_tick_count = tick_inc[TICKS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= '0;
            r_tick_count <= '0;
        end else begin
            r_stage      <= n_stage;
            r_tick_count <= n_tick_count;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

// ----- src/sgjd_drive.sv -----
// Drive computation: joint to block, stage table lookup and limit compares.
// Depends on sgjd_pkg.
`default_nettype none

module sgjd_drive
    import sgjd_pkg::*;
(
    input  wire logic [JOINT_W-1:0]        i_joint,
    input  wire logic signed [ANGLE_W-1:0] i_angle,
    input  wire logic [STAGE_W-1:0]        i_stage,
    input  wire t_cfg                      i_cfg,
    output logic signed [DRIVE_W-1:0]      o_drive
);

    localparam logic [6:0] BOUND1 = 7'(JOINTS_PER_BLOCK);
    localparam logic [6:0] BOUND2 = 7'(2 * JOINTS_PER_BLOCK);
    localparam logic [6:0] BOUND3 = 7'(3 * JOINTS_PER_BLOCK);
    localparam logic [6:0] BOUND4 = 7'(NUM_BLOCKS * JOINTS_PER_BLOCK);
    localparam logic [6:0] JOINT_LIMIT = 7'(TOTAL_JOINTS);

    logic [6:0]                 joint_w;
    logic [1:0]                 block;
    logic                       in_range;
    t_cmd                       cmd;
    logic signed [ANGLE_W-1:0]  half_hi;
    logic signed [ANGLE_W-1:0]  half_lo;
    logic signed [DRIVE_W-1:0]  pos_force;
    logic signed [DRIVE_W-1:0]  neg_force;

    always_comb begin
        joint_w  = {2'b00, i_joint};
        in_range = (joint_w < JOINT_LIMIT) && (joint_w < BOUND4);
        if (joint_w >= BOUND3) begin
            block = 2'd3;
        end else if (joint_w >= BOUND2) begin
            block = 2'd2;
        end else if (joint_w >= BOUND1) begin
            block = 2'd1;
        end else begin
            block = 2'd0;
        end
        cmd       = STAGE_CMD[i_stage][block];
        half_hi   = i_cfg.max_angle >>> 1;
        half_lo   = i_cfg.min_angle >>> 1;
        pos_force = $signed({1'b0, i_cfg.drive_force});
        neg_force = -pos_force;
        o_drive   = '0;
        if (in_range) begin
            case (cmd)
                CMD_LEFT: begin
                    if (i_angle < i_cfg.max_angle) o_drive = pos_force;
                end
                CMD_RIGHT: begin
                    if (i_angle > i_cfg.min_angle) o_drive = neg_force;
                end
                CMD_SHRINK: begin
                    if (i_angle < half_lo) begin
                        o_drive = pos_force;
                    end else if (i_angle > half_hi) begin
                        o_drive = neg_force;
                    end
                end
                default: o_drive = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/sgjd_checker.sv -----
// Port-level checker for the snake gait joint driver, bound to the top level.
// Depends on sgjd_pkg and snake_gait_joint_driver.
`default_nettype none

module sgjd_checker
    import sgjd_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic [JOINT_W-1:0]        o_joint_out,
    input wire logic signed [DRIVE_W-1:0] o_drive,
    input wire logic [STAGE_W-1:0]        o_stage_now
);

    logic r_seen_wave;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_wave <= 1'b0;
        end else if (o_valid && i_ready && o_stage_now[STAGE_W-1]) begin
            r_seen_wave <= 1'b1;
        end
    end

    // A reset leaves no result pending.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result keeps its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_joint_out) && $stable(o_drive)
            && $stable(o_stage_now))
        else $error("stalled result changed");

    // The drive magnitude never exceeds the largest seven-bit force.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_drive != -8'sd128)
        else $error("drive out of range");

    // Once the wave has begun, start-up stages never return.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_seen_wave |-> o_stage_now[STAGE_W-1])
        else $error("start-up stage after wave");

endmodule

bind snake_gait_joint_driver sgjd_checker u_sgjd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_joint_out (o_joint_out),
    .o_drive     (o_drive),
    .o_stage_now (o_stage_now)
);

`default_nettype wire

// ----- bench/snake_gait_joint_driver_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for snake_gait_joint_driver: directed table, then random gait phases.
// Checks every result against an in-bench model of gait stages and drive rules, or
// fixed values on some directed rows. Depends on sgjd_pkg and snake_gait_joint_driver RTL.

module snake_gait_joint_driver_test;

    import sgjd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [JOINT_W-1:0]        joint;
        logic signed [DRIVE_W-1:0] drive;
        logic [STAGE_W-1:0]        stage;
    } t_gait_result;

    typedef struct packed {
        logic                       is_reg;
        t_reg_idx                   idx;
        logic [CFG_DATA_W-1:0]      data;
        logic [JOINT_W-1:0]         joint;
        logic signed [ANGLE_W-1:0]  angle;
        logic                       last;
        logic                       fixed;
        logic signed [DRIVE_W-1:0]  f_drive;
        logic [STAGE_W-1:0]         f_stage;
    } t_plan_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [JOINT_W-1:0]        i_joint_index = '0;
    logic signed [ANGLE_W-1:0] i_angle = '0;
    logic                      i_last_joint = 1'b0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [JOINT_W-1:0]        o_joint_out;
    logic signed [DRIVE_W-1:0] o_drive;
    logic [STAGE_W-1:0]        o_stage_now;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    logic                      fix_en = 1'b0;
    logic signed [DRIVE_W-1:0] fix_drive = '0;
    logic [STAGE_W-1:0]        fix_stage = '0;

    logic signed [ANGLE_W-1:0] cfg_max;
    logic signed [ANGLE_W-1:0] cfg_min;
    logic [FORCE_W-1:0]        cfg_force;
    logic [TICKS_W-1:0]        cfg_ticks;
    logic [STAGE_W-1:0]        gait_stage;
    logic [TICKS_W-1:0]        gait_tick;

    t_gait_result drive_q[$];
    t_plan_row    directed_rows[$];

    logic signed [ANGLE_W-1:0] cur_max = 16'sd1787;
    logic signed [ANGLE_W-1:0] cur_min = -16'sd1787;
    int  gap_pct = 25;
    int  stall_pct = 25;
    int  mismatches = 0;
    int  cycles = 0;
    int  hold_left = 0;
    logic squeeze = 1'b0;
    logic squeezed = 1'b0;

    snake_gait_joint_driver uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_joint_index (i_joint_index),
        .i_angle       (i_angle),
        .i_last_joint  (i_last_joint),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_joint_out   (o_joint_out),
        .o_drive       (o_drive),
        .o_stage_now   (o_stage_now),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Block 0 sits in the low two bits of each row.
    function automatic logic [7:0] gait_row(input logic [STAGE_W-1:0] s);
        case (s)
            3'd0: return {CMD_NONE,   CMD_NONE,   CMD_NONE,   CMD_LEFT};
            3'd1: return {CMD_NONE,   CMD_NONE,   CMD_LEFT,   CMD_SHRINK};
            3'd2: return {CMD_NONE,   CMD_LEFT,   CMD_SHRINK, CMD_RIGHT};
            3'd3: return {CMD_LEFT,   CMD_SHRINK, CMD_RIGHT,  CMD_SHRINK};
            3'd4: return {CMD_SHRINK, CMD_RIGHT,  CMD_SHRINK, CMD_LEFT};
            3'd5: return {CMD_RIGHT,  CMD_SHRINK, CMD_LEFT,   CMD_SHRINK};
            3'd6: return {CMD_SHRINK, CMD_LEFT,   CMD_SHRINK, CMD_RIGHT};
            default: return {CMD_LEFT, CMD_SHRINK, CMD_RIGHT, CMD_SHRINK};
        endcase
    endfunction

    function automatic t_gait_result predict_drive(input logic [JOINT_W-1:0] joint,
                                                   input logic signed [ANGLE_W-1:0] angle);
        t_gait_result              r;
        logic [7:0]                row;
        logic signed [ANGLE_W-1:0] lo_half;
        logic signed [ANGLE_W-1:0] hi_half;
        logic signed [DRIVE_W-1:0] mag;
        r.joint = joint;
        r.stage = gait_stage;
        r.drive = '0;
        mag = {1'b0, cfg_force};
        lo_half = cfg_min >>> 1;
        hi_half = cfg_max >>> 1;
        if (joint < TOTAL_JOINTS) begin
            row = gait_row(gait_stage);
            case (row[2 * (joint / JOINTS_PER_BLOCK) +: 2])
                CMD_LEFT: begin
                    if (angle < cfg_max) r.drive = mag;
                end
                CMD_RIGHT: begin
                    if (angle > cfg_min) r.drive = -mag;
                end
                CMD_SHRINK: begin
                    if (angle < lo_half) r.drive = mag;
                    else if (angle > hi_half) r.drive = -mag;
                end
                default: r.drive = '0;
            endcase
        end
        return r;
    endfunction

    function automatic void advance_gait();
        logic [TICKS_W:0] bumped;
        bumped = {1'b0, gait_tick} + 1'b1;
        if (gait_stage < 3'd4) begin
            if (bumped >= {1'b0, cfg_ticks}) begin
                gait_tick = '0;
                gait_stage = gait_stage + 3'd1;
            end else begin
                gait_tick = bumped[TICKS_W-1:0];
            end
        end else if (gait_tick >= cfg_ticks) begin
            gait_tick = '0;
            gait_stage = (gait_stage == 3'd7) ? 3'd4 : gait_stage + 3'd1;
        end else begin
            gait_tick = bumped[TICKS_W-1:0];
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_gait_result want;
        t_gait_result calc;
        if (!i_rst_n) begin
            cfg_max = 16'sd1787;
            cfg_min = -16'sd1787;
            cfg_force = 7'd10;
            cfg_ticks = 8'd150;
            gait_stage = '0;
            gait_tick = '0;
        end else begin
            if (o_valid && i_ready) begin
                if (drive_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result for joint %0d", o_joint_out));
                end else begin
                    want = drive_q.pop_front();
                    if (o_joint_out !== want.joint)
                        flag_mismatch($sformatf("joint %0d, expected %0d",
                                                o_joint_out, want.joint));
                    if (o_drive !== want.drive)
                        flag_mismatch($sformatf("joint %0d drive %0d, expected %0d",
                                                want.joint, o_drive, want.drive));
                    if (o_stage_now !== want.stage)
                        flag_mismatch($sformatf("joint %0d stage %0d, expected %0d",
                                                want.joint, o_stage_now, want.stage));
                end
            end
            if (i_valid && o_ready) begin
                calc = predict_drive(i_joint_index, i_angle);
                if (fix_en) begin
                    calc.drive = fix_drive;
                    calc.stage = fix_stage;
                end
                drive_q.push_back(calc);
                if (i_last_joint) advance_gait();
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_ANGLE:   cfg_max = i_cfg_data;
                    REG_MIN_ANGLE:   cfg_min = i_cfg_data;
                    REG_DRIVE_FORCE: cfg_force = i_cfg_data[FORCE_W-1:0];
                    REG_STAGE_TICKS: cfg_ticks = i_cfg_data[TICKS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (squeeze && !squeezed) begin
            i_ready <= 1'b0;
            hold_left <= 150;
            squeezed <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void plan_sample(input logic [JOINT_W-1:0] joint,
                                        input logic signed [ANGLE_W-1:0] angle,
                                        input logic last, input logic fixed,
                                        input logic signed [DRIVE_W-1:0] d,
                                        input logic [STAGE_W-1:0] s);
        t_plan_row r;
        r = '0;
        r.joint = joint;
        r.angle = angle;
        r.last = last;
        r.fixed = fixed;
        r.f_drive = d;
        r.f_stage = s;
        directed_rows.push_back(r);
    endfunction

    function automatic void plan_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        t_plan_row r;
        r = '0;
        r.is_reg = 1'b1;
        r.idx = idx;
        r.data = data;
        directed_rows.push_back(r);
    endfunction

    task automatic offer_sample(input logic [JOINT_W-1:0] joint,
                                input logic signed [ANGLE_W-1:0] angle,
                                input logic last, input logic fixed,
                                input logic signed [DRIVE_W-1:0] d,
                                input logic [STAGE_W-1:0] s);
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_joint_index <= joint;
        i_angle <= angle;
        i_last_joint <= last;
        fix_en <= fixed;
        fix_drive <= d;
        fix_stage <= s;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (drive_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] max_v, input logic [CFG_DATA_W-1:0] min_v,
                               input logic [CFG_DATA_W-1:0] force_v,
                               input logic [CFG_DATA_W-1:0] ticks_v);
        wait_idle();
        cur_max = max_v;
        cur_min = min_v;
        put_reg(REG_MAX_ANGLE, max_v);
        put_reg(REG_MIN_ANGLE, min_v);
        put_reg(REG_DRIVE_FORCE, force_v);
        put_reg(REG_STAGE_TICKS, ticks_v);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        logic signed [ANGLE_W-1:0] h;
        logic [ANGLE_W-1:0]        nudge;
        nudge = 16'($urandom_range(2)) - 16'd1;
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return cur_max + nudge;
            3: return cur_min + nudge;
            4: begin
                h = cur_max >>> 1;
                return h + nudge;
            end
            5: begin
                h = cur_min >>> 1;
                return h + nudge;
            end
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int                  n_items;
        logic                all_last;
        logic [JOINT_W-1:0]  joint;
        logic                last;
        logic [JOINT_W-1:0]  next_joint;

        plan_sample(5'd0, 16'sh8000, 1'b0, 1'b1, 8'sd10, 3'd0);
        plan_sample(5'd0, 16'sh7FFF, 1'b0, 1'b1, 8'sd0, 3'd0);
        plan_sample(5'd0, 16'sd1787, 1'b0, 1'b1, 8'sd0, 3'd0);
        plan_sample(5'd0, 16'sd1786, 1'b0, 1'b1, 8'sd10, 3'd0);
        plan_sample(5'd5, 16'sd0, 1'b0, 1'b1, 8'sd0, 3'd0);
        plan_sample(5'd20, 16'sh8000, 1'b0, 1'b1, 8'sd0, 3'd0);
        plan_sample(5'd31, 16'sd0, 1'b1, 1'b1, 8'sd0, 3'd0);
        plan_reg(REG_STAGE_TICKS, 16'h0000);
        plan_reg(REG_DRIVE_FORCE, 16'hFFFF);
        plan_sample(5'd19, 16'sd0, 1'b1, 1'b1, 8'sd0, 3'd0);
        plan_sample(5'd0, 16'sh8000, 1'b0, 1'b1, 8'sd127, 3'd1);
        plan_sample(5'd4, 16'sh7FFF, 1'b0, 1'b1, -8'sd127, 3'd1);
        plan_sample(5'd4, -16'sd894, 1'b0, 1'b0, '0, '0);
        plan_sample(5'd4, 16'sd894, 1'b0, 1'b0, '0, '0);
        plan_sample(5'd9, 16'sd0, 1'b1, 1'b0, '0, '0);
        plan_sample(5'd0, -16'sd1787, 1'b0, 1'b0, '0, '0);
        plan_sample(5'd14, 16'sh7FFF, 1'b1, 1'b0, '0, '0);
        plan_sample(5'd15, 16'sd0, 1'b1, 1'b0, '0, '0);
        plan_sample(5'd19, 16'sd0, 1'b1, 1'b0, '0, '0);
        plan_sample(5'd10, 16'sd0, 1'b1, 1'b0, '0, '0);
        plan_sample(5'd17, 16'sd0, 1'b1, 1'b0, '0, '0);
        plan_sample(5'd3, 16'sd0, 1'b1, 1'b0, '0, '0);
        plan_reg(REG_MAX_ANGLE, 16'hFF9C);
        plan_reg(REG_MIN_ANGLE, 16'd100);
        plan_sample(5'd5, 16'sd0, 1'b0, 1'b0, '0, '0);
        plan_sample(5'd12, 16'sd200, 1'b0, 1'b0, '0, '0);
        plan_sample(5'd0, -16'sd200, 1'b0, 1'b0, '0, '0);
        plan_sample(5'd16, 16'sd75, 1'b1, 1'b0, '0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_reg) begin
                if (r == 0 || !directed_rows[r-1].is_reg) wait_idle();
                put_reg(directed_rows[r].idx, directed_rows[r].data);
                if (r + 1 == directed_rows.size() || !directed_rows[r+1].is_reg)
                    i_cfg_we <= 1'b0;
            end else begin
                offer_sample(directed_rows[r].joint, directed_rows[r].angle,
                             directed_rows[r].last, directed_rows[r].fixed,
                             directed_rows[r].f_drive, directed_rows[r].f_stage);
            end
        end

        next_joint = '0;
        for (int p = 0; p < 8; p++) begin
            n_items = 250;
            all_last = 1'b0;
            gap_pct = 25;
            stall_pct <= 25;
            case (p)
                0: load_config(16'($urandom_range(4000, 500)), -16'($urandom_range(4000, 500)),
                               {9'($urandom), 7'($urandom_range(126, 1))}, {8'($urandom), 8'd1});
                1: begin
                    load_config(16'h7FFF, 16'h8000, 16'h007F, 16'h0000);
                    gap_pct = 0;
                    stall_pct <= 0;
                end
                2: load_config(16'd1000, -16'd1000, {9'($urandom), 7'd0}, {8'($urandom), 8'd2});
                3: begin
                    load_config(-16'($urandom_range(3000, 1)), 16'($urandom_range(3000, 1)),
                                16'($urandom), {8'($urandom), 8'd1});
                    gap_pct = 0;
                    squeeze <= 1'b1;
                end
                4: begin
                    load_config(16'd1787, -16'd1787, 16'd10, 16'h00FF);
                    n_items = 270;
                    all_last = 1'b1;
                end
                6: load_config(16'h8000, 16'h7FFF, 16'd64, 16'd1);
                default: load_config(16'($urandom), 16'($urandom), 16'($urandom),
                                     {8'($urandom), 8'($urandom_range(5))});
            endcase
            for (int k = 0; k < n_items; k++) begin
                if (all_last) begin
                    joint = 5'($urandom_range(19));
                    last = 1'b1;
                end else if ($urandom_range(99) < 12) begin
                    joint = 5'($urandom_range(31));
                    last = 1'($urandom_range(1));
                end else begin
                    joint = next_joint;
                    last = (next_joint == 5'd19);
                    next_joint = last ? 5'd0 : next_joint + 5'd1;
                end
                offer_sample(joint, pick_angle(), last, 1'b0, '0, '0);
            end
        end

        wait_idle();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/sgjd_pkg.sv
src/sgjd_cfg.sv
src/sgjd_timer.sv
src/sgjd_drive.sv
src/snake_gait_joint_driver.sv
src/sgjd_checker.sv
bench/snake_gait_joint_driver_test.sv
